### src/conv2d_valid_stream_assert.svh
// ----------------------------------------------------------------------------
// conv2d_valid_stream assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CONV2D_VALID_STREAM_ASSERT_SVH
`define CONV2D_VALID_STREAM_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define CVS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CVS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// same-cycle implication that also runs across reset
`define CVS_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

### src/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg
// shared types, register codes and widths of the streaming convolution
// ----------------------------------------------------------------------------
`default_nettype none

package cvs_pkg;

   localparam int KSZ_W      = 2;
   localparam int ISZ_W      = 9;
   localparam int COEF_W     = 16;
   localparam int NUM_COEF   = 9;
   localparam int COEF_IDX_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam int KERNEL_RESET = 3;
   localparam int IMAGE_RESET  = 256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_SIZE = 3'd0,
      CSR_IMAGE_SIZE  = 3'd1,
      CSR_COEF_A      = 3'd2,
      CSR_COEF_B      = 3'd3,
      CSR_COEF_C      = 3'd4
   } csr_index_type;

   // hand-off from the line stage into the accumulate pipeline
   typedef struct packed {
      logic load;
      logic last;
   } beat_type;

   // width rounded up to whole bytes
   function automatic int pad8(input int w);
      return ((w + 7) >> 3) << 3;
   endfunction

endpackage

`default_nettype wire

### src/cvs_line_store.sv
// ----------------------------------------------------------------------------
// cvs_line_store
// line memory indexed by column, registered read with write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_line_store #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   logic [WIDTH-1:0] fwd_data_ff;
   logic             fwd_ff;
   logic             fwd_in;

   assign fwd_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   // same column written back in the read cycle: take the new entry
   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;

endmodule

`default_nettype wire

### src/cvs_window.sv
// ----------------------------------------------------------------------------
// cvs_window
// kernel window registers, coefficient placement and tap multipliers
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_window #(
   parameter int MAX_KERNEL = 3,
   parameter int DATA_WIDTH = 16,
   localparam int LINES  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1,
   localparam int TAPS   = MAX_KERNEL * MAX_KERNEL,
   localparam int PROD_W = DATA_WIDTH + cvs_pkg::COEF_W
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        shift_en,
   input  wire logic                                        load_en,
   input  wire logic [LINES*DATA_WIDTH-1:0]                 line_data,
   input  wire logic [DATA_WIDTH-1:0]                       pixel,
   input  wire logic [cvs_pkg::KSZ_W-1:0]                   kernel_eff,
   input  wire logic [cvs_pkg::NUM_COEF*cvs_pkg::COEF_W-1:0] coefs,
   output logic      [TAPS*PROD_W-1:0]                      prod
);

   logic [DATA_WIDTH-1:0]      win_ff   [TAPS];
   logic [DATA_WIDTH-1:0]      win_in   [TAPS];
   logic [cvs_pkg::COEF_W-1:0] coef_arr [cvs_pkg::NUM_COEF];
   logic [cvs_pkg::COEF_W-1:0] cmap_ff  [TAPS];
   logic [cvs_pkg::COEF_W-1:0] cmap_in  [TAPS];
   logic [PROD_W-1:0]          prod_ff  [TAPS];

   for (genvar gi = 0; gi < cvs_pkg::NUM_COEF; gi++) begin : g_coef
      assign coef_arr[gi] = coefs[gi*cvs_pkg::COEF_W +: cvs_pkg::COEF_W];
   end

   // shift left, new column on the right: older lines on top, pixel at bottom
   always_comb begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
         for (int c = 0; c + 1 < MAX_KERNEL; c++) begin
            win_in[r*MAX_KERNEL + c] = win_ff[r*MAX_KERNEL + c + 1];
         end
      end
      for (int r = 0; r + 1 < MAX_KERNEL; r++) begin
         win_in[r*MAX_KERNEL + MAX_KERNEL - 1] =
            line_data[(MAX_KERNEL - 2 - r)*DATA_WIDTH +: DATA_WIDTH];
      end
      win_in[TAPS-1] = pixel;
   end

   // a smaller kernel sits in the bottom-right corner of the window
   always_comb begin
      int base;
      int idx;
      base = MAX_KERNEL - int'(kernel_eff);
      for (int r = 0; r < MAX_KERNEL; r++) begin
         for (int c = 0; c < MAX_KERNEL; c++) begin
            idx = (r - base) * int'(kernel_eff) + (c - base);
            if (r >= base && c >= base && idx < cvs_pkg::NUM_COEF) begin
               cmap_in[r*MAX_KERNEL + c] = coef_arr[cvs_pkg::COEF_IDX_W'(idx)];
            end else begin
               cmap_in[r*MAX_KERNEL + c] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < TAPS; t++) begin
         cmap_ff[t] <= cmap_in[t];
         if (load_en) begin
            // taps outside the kernel may hold line data never written
            prod_ff[t] <= (cmap_ff[t] == '0) ? '0
                          : PROD_W'($signed(win_in[t]) * $signed(cmap_ff[t]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TAPS; t++) begin
            win_ff[t] <= '0;
         end
      end else if (shift_en) begin
         for (int t = 0; t < TAPS; t++) begin
            win_ff[t] <= win_in[t];
         end
      end
   end

   for (genvar gt = 0; gt < TAPS; gt++) begin : g_prod
      assign prod[gt*PROD_W +: PROD_W] = prod_ff[gt];
   end

endmodule

`default_nettype wire

### src/cvs_mac.sv
// ----------------------------------------------------------------------------
// cvs_mac
// registered adder tree over the tap products and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_mac #(
   parameter int MAX_KERNEL = 3,
   parameter int DATA_WIDTH = 16,
   localparam int TAPS   = MAX_KERNEL * MAX_KERNEL,
   localparam int PROD_W = DATA_WIDTH + cvs_pkg::COEF_W,
   localparam int OUT_W  = 2 * DATA_WIDTH + 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cvs_pkg::beat_type      beat,
   output logic                        in_ready,
   input  wire logic [TAPS*PROD_W-1:0] prod,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [OUT_W-1:0]       conv_value,
   output logic                        frame_last
);

   localparam int SUMW   = (OUT_W > PROD_W + 4) ? OUT_W : PROD_W + 4;

   logic            s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic            s2_last_ff, s3_last_ff, s4_last_ff;
   logic            s2_adv, s3_adv, s3_ready, s4_ready;
   logic [SUMW-1:0] row_sum_ff [MAX_KERNEL];
   logic [SUMW-1:0] row_sum_in [MAX_KERNEL];
   logic [SUMW-1:0] total_in;
   logic [OUT_W-1:0] total_ff;

   assign s4_ready = !s4_valid_ff || rsp_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = !s2_valid_ff || s3_ready;
   assign s2_adv   = s2_valid_ff && s3_ready;
   assign s3_adv   = s3_valid_ff && s4_ready;

   always_comb begin
      logic [PROD_W-1:0] p;
      for (int r = 0; r < MAX_KERNEL; r++) begin
         row_sum_in[r] = '0;
         for (int c = 0; c < MAX_KERNEL; c++) begin
            p = prod[(r*MAX_KERNEL + c)*PROD_W +: PROD_W];
            row_sum_in[r] = row_sum_in[r] + {{(SUMW-PROD_W){p[PROD_W-1]}}, p};
         end
      end
   end

   always_comb begin
      total_in = '0;
      for (int r = 0; r < MAX_KERNEL; r++) begin
         total_in = total_in + row_sum_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (beat.load) begin
         s2_last_ff <= beat.last;
      end
      if (s2_adv) begin
         s3_last_ff <= s2_last_ff;
         for (int r = 0; r < MAX_KERNEL; r++) begin
            row_sum_ff[r] <= row_sum_in[r];
         end
      end
      if (s3_adv) begin
         s4_last_ff <= s3_last_ff;
         total_ff   <= total_in[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (beat.load) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_adv) begin
            s3_valid_ff <= 1'b1;
         end else if (s3_adv) begin
            s3_valid_ff <= 1'b0;
         end
         if (s3_adv) begin
            s4_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            s4_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = s4_valid_ff;
   assign conv_value = total_ff;
   assign frame_last = s4_last_ff;

endmodule

`default_nettype wire

### src/conv2d_valid_stream.sv
// ----------------------------------------------------------------------------
// conv2d_valid_stream
// streaming 2-D convolution over a square image, valid windows only
// ----------------------------------------------------------------------------
// usage
//   req_ channel takes one pixel per request in raster order; req_tuser set
//   marks the first pixel of a frame and restarts the row and column counters
//   rsp_ channel gives one signed Q19.16 sum for every window that lies fully
//   inside the image; rsp_tlast marks the bottom-right window of the frame
//   csr_ channel writes kernel_size, image_size and the three coefficient
//   groups by index; writing a size restarts the counters
// throughput: one pixel per clock while the result stream is not stalled;
//   the line memory does one read and one write-back per pixel, with
//   forwarding when the same column is read and written back in the same cycle
// path: the line memory is read at accept, then the products, row sums and
//   total are registered in turn before rsp_tvalid rises
// reset: clears counters, window and pipeline valid bits and loads the
//   register defaults; the line memory is not cleared, kernel taps never read
//   a column before the frame has written it, and taps outside the kernel give
//   a zero product; req_tready and csr_ready are low while reset is high
// stall: a held result keeps rsp_tdata and rsp_tlast steady; the three
//   internal stages behind it keep taking requests until they fill
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_valid_stream #(
   parameter int MAX_IMAGE  = 256,
   parameter int MAX_KERNEL = 3,
   parameter int DATA_WIDTH = 16,
   localparam int OUT_W  = 2 * DATA_WIDTH + 3,
   localparam int REQ_W  = cvs_pkg::pad8(DATA_WIDTH),
   localparam int RSP_W  = cvs_pkg::pad8(OUT_W)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [REQ_W-1:0]                  req_tdata,   // pixel
   input  wire logic                              req_tuser,   // frame_start
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [RSP_W-1:0]                  rsp_tdata,   // conv_value
   output logic                                   rsp_tlast,   // frame_last
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cvs_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW     = $clog2(MAX_IMAGE);
   localparam int CW     = (cvs_pkg::ISZ_W > AW + 1) ? cvs_pkg::ISZ_W : AW + 1;
   localparam int LINES  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;
   localparam int PROD_W = DATA_WIDTH + cvs_pkg::COEF_W;

   // configuration registers
   logic [cvs_pkg::KSZ_W-1:0]  kernel_size_ff;
   logic [cvs_pkg::ISZ_W-1:0]  image_size_ff;
   logic [63:0]                coef_a_ff;
   logic [63:0]                coef_b_ff;
   logic [cvs_pkg::COEF_W-1:0] coef_c_ff;
   logic                       csr_write;
   logic                       size_write;

   // effective sizes after clamping
   logic [cvs_pkg::KSZ_W-1:0]  kernel_eff;
   logic [CW-1:0]              image_eff;
   logic [CW-1:0]              kernel_ext;

   // frame position
   logic [AW-1:0] row_ff, col_ff, row_in, col_in;
   logic [AW-1:0] cur_row, cur_col;
   logic [CW-1:0] row_p1, col_p1;
   logic          emit, last;
   logic          accept;

   // line stage
   logic                    s1_valid_ff;
   logic [DATA_WIDTH-1:0]   s1_pix_ff;
   logic [AW-1:0]           s1_col_ff;
   logic                    s1_emit_ff, s1_last_ff;
   logic                    s1_adv;
   logic                    s2_ready;
   logic [LINES*DATA_WIDTH-1:0] line_data;
   logic [LINES*DATA_WIDTH-1:0] line_wr;
   logic [TAPS*PROD_W-1:0]  prod;
   cvs_pkg::beat_type       beat;
   logic [OUT_W-1:0]        conv_value;

   // ---------------- register port ----------------
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;
   assign size_write = csr_write &&
      (csr_index == cvs_pkg::CSR_KERNEL_SIZE || csr_index == cvs_pkg::CSR_IMAGE_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff <= cvs_pkg::KSZ_W'(cvs_pkg::KERNEL_RESET);
         image_size_ff  <= cvs_pkg::ISZ_W'(cvs_pkg::IMAGE_RESET);
         coef_a_ff      <= '0;
         coef_b_ff      <= '0;
         coef_c_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            cvs_pkg::CSR_KERNEL_SIZE: kernel_size_ff <= csr_data[cvs_pkg::KSZ_W-1:0];
            cvs_pkg::CSR_IMAGE_SIZE:  image_size_ff  <= csr_data[cvs_pkg::ISZ_W-1:0];
            cvs_pkg::CSR_COEF_A:      coef_a_ff      <= csr_data;
            cvs_pkg::CSR_COEF_B:      coef_b_ff      <= csr_data;
            cvs_pkg::CSR_COEF_C:      coef_c_ff      <= csr_data[cvs_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // zero means one, oversize saturates
   always_comb begin
      if (kernel_size_ff == '0) begin
         kernel_eff = cvs_pkg::KSZ_W'(1);
      end else if (int'(kernel_size_ff) > MAX_KERNEL) begin
         kernel_eff = cvs_pkg::KSZ_W'(MAX_KERNEL);
      end else begin
         kernel_eff = kernel_size_ff;
      end
      if (image_size_ff == '0) begin
         image_eff = CW'(1);
      end else if (CW'(image_size_ff) > CW'(MAX_IMAGE)) begin
         image_eff = CW'(MAX_IMAGE);
      end else begin
         image_eff = CW'(image_size_ff);
      end
      kernel_ext = CW'(kernel_eff);
   end

   // ---------------- frame counters ----------------
   assign accept = req_tvalid && req_tready;

   always_comb begin
      cur_row = req_tuser ? '0 : row_ff;
      cur_col = req_tuser ? '0 : col_ff;
      row_p1  = CW'(cur_row) + CW'(1);
      col_p1  = CW'(cur_col) + CW'(1);
      emit    = (image_eff >= kernel_ext) && (row_p1 >= kernel_ext) &&
                (col_p1 >= kernel_ext);
      last    = (row_p1 == image_eff) && (col_p1 == image_eff);
      // wrap at the end of a row, and of the frame
      if (col_p1 >= image_eff) begin
         col_in = '0;
         row_in = (row_p1 >= image_eff) ? '0 : row_p1[AW-1:0];
      end else begin
         col_in = col_p1[AW-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || size_write) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- line stage ----------------
   // items that complete no window retire here
   assign s1_adv     = s1_valid_ff && (!s1_emit_ff || s2_ready);
   assign req_tready = !reset && (!s1_valid_ff || s1_adv);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_tdata[DATA_WIDTH-1:0];
         s1_col_ff  <= cur_col;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // entry 0 is the row above, each older line moves down one slot
   always_comb begin
      line_wr[DATA_WIDTH-1:0] = s1_pix_ff;
      for (int j = 1; j < LINES; j++) begin
         line_wr[j*DATA_WIDTH +: DATA_WIDTH] = line_data[(j-1)*DATA_WIDTH +: DATA_WIDTH];
      end
   end

   cvs_line_store #(
      .DEPTH (MAX_IMAGE),
      .WIDTH (LINES * DATA_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_data (line_data)
   );

   assign beat = cvs_pkg::beat_type'{load: s1_adv && s1_emit_ff, last: s1_last_ff};

   cvs_window #(
      .MAX_KERNEL (MAX_KERNEL),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (s1_adv),
      .load_en    (beat.load),
      .line_data  (line_data),
      .pixel      (s1_pix_ff),
      .kernel_eff (kernel_eff),
      .coefs      ({coef_c_ff, coef_b_ff, coef_a_ff}),
      .prod       (prod)
   );

   // ---------------- accumulate and result ----------------
   cvs_mac #(
      .MAX_KERNEL (MAX_KERNEL),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .in_ready   (s2_ready),
      .prod       (prod),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .conv_value (conv_value),
      .frame_last (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'(conv_value);

endmodule

`default_nettype wire

### src/cvs_port_checker.sv
// ----------------------------------------------------------------------------
// cvs_port_checker
// port-level checks on the streaming convolution, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "conv2d_valid_stream_assert.svh"

module cvs_port_checker #(
   parameter int RSP_W = 40
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             rsp_tlast
);

   // a held result keeps its payload
   `CVS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // leaving reset the pipe is empty and open
   `CVS_ASSERT_ALWAYS(a_reset_empty, clock, $fell(reset), !rsp_tvalid && req_tready, "pipe not empty after reset")

   // a fresh result comes from an earlier accepted request
   `CVS_ASSERT_IMPLY(a_rsp_latency, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 4), "result without matching request")

endmodule

bind conv2d_valid_stream cvs_port_checker #(
   .RSP_W (cvs_pkg::pad8(2 * DATA_WIDTH + 3))
) u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the streaming valid-window 2-D convolution: a
// clocked driver feeds pixels from a queue, a clocked monitor checks every
// window sum against an in-bench model of the line stores and window
// ----------------------------------------------------------------------------

module tb;

   localparam int PIX_W       = 16;
   localparam int SUM_W       = 35;
   localparam int REQ_W       = cvs_pkg::pad8(PIX_W);
   localparam int RSP_W       = cvs_pkg::pad8(SUM_W);
   localparam int MAX_IMAGE   = 256;
   localparam int SETTLE      = 8;      // pipeline depth plus margin
   localparam int LONG_HOLD   = 300;    // receiver hold-off, in cycles
   localparam int IDLE_LIMIT  = 2000;   // cycles with no handshake at all
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 1350;

   // one pending pixel request
   typedef struct {
      logic [PIX_W-1:0] pix;
      logic             start;
   } pixel_item_type;

   // one expected window sum
   typedef struct {
      logic [SUM_W-1:0] sum;
      logic             last;
   } window_sum_type;

   // ---------------------------------------------------------------------
   // block ports, every input known from time zero
   // ---------------------------------------------------------------------
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_W-1:0]               req_tdata  = '0;   // pixel
   logic                           req_tuser  = 1'b0; // frame_start
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [RSP_W-1:0]               rsp_tdata;         // conv_value
   logic                           rsp_tlast;         // frame_last
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [cvs_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [cvs_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   conv2d_valid_stream u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // model state: registers, line stores, window and raster counters
   // ---------------------------------------------------------------------
   logic [cvs_pkg::KSZ_W-1:0] cfg_kernel;
   logic [cvs_pkg::ISZ_W-1:0] cfg_image;
   logic [63:0]       coef_a;
   logic [63:0]       coef_b;
   logic [15:0]       coef_c;
   logic [PIX_W-1:0]  line_mem [2][MAX_IMAGE];  // 0: row above, 1: two rows above
   logic [PIX_W-1:0]  win [3][3];
   int                row_cnt;
   int                col_cnt;

   pixel_item_type pixel_q [$];        // requests waiting for the driver
   window_sum_type window_sums_q [$];  // sums still owed by the block

   // shared control between stimulus, driver and monitor
   logic        req_steady = 1'b0;  // no sender gaps this phase
   logic        rsp_steady = 1'b0;  // no receiver stalls this phase
   int          hold_ask   = 0;     // bumped to ask for one long hold-off
   int          fail_count = 0;

   // driver and monitor locals
   pixel_item_type req_item;
   int             req_gap     = 0;
   int             rsp_wait    = 0;
   int             hold_seen   = 0;
   int             idle_cycles = 0;
   window_sum_type oldest_sum;
   logic           rsp_bad;

   function automatic int eff_image();
      if (cfg_image == 0) return 1;
      if (cfg_image > MAX_IMAGE) return MAX_IMAGE;
      return int'(cfg_image);
   endfunction

   // q8.8 value, either anywhere in range or one of the corner values
   function automatic logic [15:0] draw_q88(input bit extreme);
      logic [15:0] corner [6] = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000,
                                  16'h0001, 16'h0100};
      if (extreme) return corner[$urandom_range(0, 5)];
      return 16'($urandom);
   endfunction

   // advance the window by one pixel and queue the sum if a full window
   // lies inside the image
   task automatic convolve_pixel(input logic [PIX_W-1:0] pix, input logic start);
      int                n;
      int                k;
      int                col;
      int                base;
      int                idx;
      logic [15:0]       cf;
      logic signed [63:0] acc;
      n = eff_image();
      k = (cfg_kernel == 0) ? 1 : int'(cfg_kernel);
      if (start) begin
         row_cnt = 0;
         col_cnt = 0;
      end
      col = (col_cnt >= MAX_IMAGE) ? MAX_IMAGE - 1 : col_cnt;
      // shift left, new column on the right
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 2; c++)
            win[r][c] = win[r][c + 1];
      win[0][2] = line_mem[1][col];
      win[1][2] = line_mem[0][col];
      win[2][2] = pix;
      line_mem[1][col] = line_mem[0][col];
      line_mem[0][col] = pix;
      if (n >= k && row_cnt + 1 >= k && col_cnt + 1 >= k) begin
         acc  = '0;
         base = 3 - k;
         for (int r = 0; r < k; r++)
            for (int c = 0; c < k; c++) begin
               idx = r * k + c;
               if (idx < 4) cf = coef_a[16 * idx +: 16];
               else if (idx < 8) cf = coef_b[16 * (idx - 4) +: 16];
               else cf = coef_c;
               acc += 64'($signed(win[base + r][base + c])) * 64'($signed(cf));
            end
         window_sums_q.push_back('{acc[SUM_W-1:0],
                                   (row_cnt + 1 == n && col_cnt + 1 == n)});
      end
      if (col_cnt + 1 >= n) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1 >= n) ? 0 : row_cnt + 1;
      end else begin
         col_cnt++;
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: one pixel request per queue entry, random gap after each
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    = 0;
         cfg_kernel = cvs_pkg::KSZ_W'(cvs_pkg::KERNEL_RESET);
         cfg_image  = cvs_pkg::ISZ_W'(cvs_pkg::IMAGE_RESET);
         coef_a     = '0;
         coef_b     = '0;
         coef_c     = '0;
         row_cnt    = 0;
         col_cnt    = 0;
         foreach (win[r, c]) win[r][c] = '0;
         foreach (line_mem[r, c]) line_mem[r][c] = '0;
      end else begin
         // request taken at this edge: predict its sum
         if (req_tvalid && req_tready) convolve_pixel(req_item.pix, req_item.start);
         // free to move on unless a request is still being offered
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
               req_item = pixel_q.pop_front();
               req_tdata  <= req_item.pix;
               req_tuser  <= req_item.start;
               req_tvalid <= 1'b1;
               req_gap = req_steady ? 0 : $urandom_range(0, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: check each taken result, then stall for a random while
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait  = 0;
         hold_seen = hold_ask;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (window_sums_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result: conv_value %0d frame_last %b",
                           $signed(rsp_tdata[SUM_W-1:0]), rsp_tlast);
            end else begin
               oldest_sum = window_sums_q.pop_front();
               rsp_bad = (rsp_tdata[SUM_W-1:0] !== oldest_sum.sum) ||
                         (rsp_tdata[RSP_W-1:SUM_W] !== '0) ||
                         (rsp_tlast !== oldest_sum.last);
               if (rsp_bad) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"mismatch: conv_value exp %0d got %0d (tdata %h), ",
                               "frame_last exp %b got %b"},
                              $signed(oldest_sum.sum), $signed(rsp_tdata[SUM_W-1:0]),
                              rsp_tdata, oldest_sum.last, rsp_tlast);
               end
            end
            rsp_wait = rsp_steady ? 0 : $urandom_range(0, 8);
         end
         // long hold-off asked for by the stimulus
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            rsp_wait  = LONG_HOLD;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without any handshake ends the run
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   int items_sent = 0;

   // register write; size writes also restart the model counters
   task automatic csr_write(input cvs_pkg::csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         cvs_pkg::CSR_KERNEL_SIZE: begin
            cfg_kernel = value[cvs_pkg::KSZ_W-1:0];
            row_cnt = 0;
            col_cnt = 0;
         end
         cvs_pkg::CSR_IMAGE_SIZE: begin
            cfg_image = value[cvs_pkg::ISZ_W-1:0];
            row_cnt = 0;
            col_cnt = 0;
         end
         cvs_pkg::CSR_COEF_A: coef_a = value;
         cvs_pkg::CSR_COEF_B: coef_b = value;
         cvs_pkg::CSR_COEF_C: coef_c = value[15:0];
         default: ;
      endcase
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic start);
      pixel_q.push_back('{pix, start});
      items_sent++;
   endtask

   // sender stops until every owed sum has come back
   task automatic wait_results();
      do @(negedge clock);
      while (pixel_q.size() != 0 || req_tvalid || window_sums_q.size() != 0);
   endtask

   // block idle: owed sums back, plus time for requests that owe nothing
   task automatic drain();
      wait_results();
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int          phase;
      int          ksz;
      int          nsz;
      int          pick;
      int          frame_n;
      int          frames;
      int          tail;
      bit          extreme;
      logic [63:0] word;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // -- directed --
      // 1x1 kernel on 1x1 frames: every pixel is a full frame and its last sum
      csr_write(cvs_pkg::CSR_KERNEL_SIZE, 64'd1);
      csr_write(cvs_pkg::CSR_IMAGE_SIZE, 64'd1);
      csr_write(cvs_pkg::CSR_COEF_A, {48'h0, 16'h8000});
      csr_write(cvs_pkg::CSR_COEF_B, {4{16'h7fff}});
      csr_write(cvs_pkg::CSR_COEF_C, {48'hdead_beef_0000, 16'h8000});
      @(negedge clock);
      push_pixel(16'h8000, 1'b1);
      push_pixel(16'h7fff, 1'b0);
      push_pixel(16'h0000, 1'b1);
      push_pixel(16'hffff, 1'b0);
      drain();

      // zero sizes behave as one
      csr_write(cvs_pkg::CSR_KERNEL_SIZE, 64'd0);
      csr_write(cvs_pkg::CSR_IMAGE_SIZE, 64'd0);
      @(negedge clock);
      push_pixel(16'h8000, 1'b0);
      push_pixel(16'h0001, 1'b1);
      drain();

      // image smaller than the kernel: no window ever fits
      csr_write(cvs_pkg::CSR_KERNEL_SIZE, 64'd3);
      csr_write(cvs_pkg::CSR_IMAGE_SIZE, 64'd2);
      @(negedge clock);
      push_pixel(16'h1234, 1'b1);
      for (int i = 0; i < 3; i++) push_pixel(16'($urandom), 1'b0);
      drain();

      // full-scale 3x3 window; a size write midway restarts the raster
      csr_write(cvs_pkg::CSR_IMAGE_SIZE, 64'd3);
      csr_write(cvs_pkg::CSR_COEF_A, {4{16'h8000}});
      csr_write(cvs_pkg::CSR_COEF_B, {4{16'h8000}});
      csr_write(cvs_pkg::CSR_COEF_C, {48'h0, 16'h8000});
      @(negedge clock);
      for (int i = 0; i < 4; i++) push_pixel(16'($urandom), 1'b0);
      drain();
      csr_write(cvs_pkg::CSR_IMAGE_SIZE, 64'd3);
      @(negedge clock);
      for (int i = 0; i < 9; i++) push_pixel(16'h8000, 1'b0);
      drain();

      // -- random phases --
      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         phase++;
         extreme = ($urandom_range(0, 4) == 0);
         if (phase == 5) begin
            // widest image (oversize value saturates), two rows of a 2x2 kernel
            csr_write(cvs_pkg::CSR_KERNEL_SIZE, 64'd2);
            csr_write(cvs_pkg::CSR_IMAGE_SIZE, 64'd300);
            csr_write(cvs_pkg::CSR_COEF_A,
                      {draw_q88(0), draw_q88(0), draw_q88(0), draw_q88(0)});
            @(negedge clock);
            req_steady <= ($urandom_range(0, 1) == 0);
            rsp_steady <= ($urandom_range(0, 1) == 0);
            push_pixel(16'($urandom), 1'b1);
            for (int i = 1; i < 2 * MAX_IMAGE; i++) push_pixel(16'($urandom), 1'b0);
         end else begin
            if (phase < 3 || $urandom_range(0, 2) != 0) begin
               pick = $urandom_range(0, 7);
               case (pick)
                  0:       ksz = 0;
                  1:       ksz = 1;
                  2, 3:    ksz = 2;
                  default: ksz = 3;
               endcase
               word = {$urandom, $urandom};
               word[cvs_pkg::KSZ_W-1:0] = cvs_pkg::KSZ_W'(ksz);
               csr_write(cvs_pkg::CSR_KERNEL_SIZE, word);
            end
            // right after the widest image the size is always brought back down
            if (phase < 3 || phase == 6 || $urandom_range(0, 2) != 0) begin
               pick = $urandom_range(0, 19);
               if (pick == 0) nsz = 0;
               else if (pick < 3) nsz = $urandom_range(7, 12);
               else nsz = $urandom_range(1, 6);
               word = {$urandom, $urandom};
               word[cvs_pkg::ISZ_W-1:0] = cvs_pkg::ISZ_W'(nsz);
               csr_write(cvs_pkg::CSR_IMAGE_SIZE, word);
            end
            if ($urandom_range(0, 1) == 0)
               csr_write(cvs_pkg::CSR_COEF_A, {draw_q88(extreme), draw_q88(extreme),
                                               draw_q88(extreme), draw_q88(extreme)});
            if ($urandom_range(0, 1) == 0)
               csr_write(cvs_pkg::CSR_COEF_B, {draw_q88(extreme), draw_q88(extreme),
                                               draw_q88(extreme), draw_q88(extreme)});
            if ($urandom_range(0, 1) == 0)
               csr_write(cvs_pkg::CSR_COEF_C, {16'($urandom), 16'($urandom),
                                               16'($urandom), draw_q88(extreme)});
            frame_n = eff_image();
            frames  = $urandom_range(1, 2);
            @(negedge clock);
            // receiver holds off while the sender keeps offering
            if (phase % 9 == 4) begin
               req_steady <= 1'b1;
               rsp_steady <= 1'b0;
               hold_ask   <= hold_ask + 1;
            end else begin
               req_steady <= ($urandom_range(0, 3) == 0);
               rsp_steady <= ($urandom_range(0, 3) == 0);
            end
            for (int f = 0; f < frames; f++) begin
               for (int p = 0; p < frame_n * frame_n; p++)
                  push_pixel(draw_q88(extreme),
                             (p == 0) ? ($urandom_range(0, 3) != 0)
                                      : ($urandom_range(0, 49) == 0));
               // sender pauses mid-phase until every owed sum has come back
               if (f == 0 && phase % 5 == 2) wait_results();
            end
            // partial frame left open for the next phase
            tail = $urandom_range(0, frame_n * frame_n - 1);
            for (int p = 0; p < tail; p++) push_pixel(draw_q88(extreme), 1'b0);
         end
         drain();
      end

      // -- end of run --
      drain();
      if (fail_count == 0 && window_sums_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### conv2d_valid_stream.f
+incdir+src
src/cvs_pkg.sv
src/cvs_line_store.sv
src/cvs_window.sv
src/cvs_mac.sv
src/conv2d_valid_stream.sv
src/cvs_port_checker.sv
dv/tb.sv
